// ----- sv/sdfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sdfa_pkg
// Types and constants shared by the spring-damper force accumulator modules.
// ----------------------------------------------------------------------------
package sdfa_pkg;

  // queue between front and back (power of two)
  localparam int QDEPTH = 2;

  localparam logic [2:0] REG_STIFFNESS = 3'd0;
  localparam logic [2:0] REG_DAMPING   = 3'd1;
  localparam logic [2:0] REG_GRAVITY_X = 3'd2;
  localparam logic [2:0] REG_GRAVITY_Y = 3'd3;
  localparam logic [2:0] REG_GRAVITY_Z = 3'd4;

  typedef enum logic [1:0] {
    OP_BEGIN_DYN,
    OP_BEGIN_STATIC,
    OP_LINK,
    OP_SKIP
  } op_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_GRAV,
    B_GRAV_SUM,
    B_DIFF,
    B_MAG,
    B_SQ,
    B_SQRT,
    B_DSTART,
    B_DIV,
    B_DOT,
    B_DOT_SUM,
    B_SMUL,
    B_SCAL,
    B_FMUL,
    B_FUPD,
    B_DONE
  } bstate_t;

  typedef struct packed {
    op_t                    op;
    logic [2:0][31:0]       pos;
    logic [2:0][31:0]       vel;
    logic [30:0]            rest_length;
    logic [30:0]            mass;
    logic                   last;
  } entry_t;

  typedef struct packed {
    logic [30:0]            stiffness;
    logic [30:0]            damping;
    logic [2:0][31:0]       gravity;
  } cfg_t;

endpackage

// ----- sv/sdfa_front.sv -----
// ----------------------------------------------------------------------------
// sdfa_front
// Accepts items and classifies them against the current particle's flag.
// ----------------------------------------------------------------------------
module sdfa_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               cmd,
  input  logic [2:0][31:0]   pos,
  input  logic [2:0][31:0]   vel,
  input  logic [30:0]        rest_length,
  input  logic [30:0]        mass,
  input  logic               dynamic,
  input  logic               last,
  input  logic               q_full,
  output logic               push,
  output sdfa_pkg::entry_t   entry
);
  import sdfa_pkg::*;

  logic dyn_flag;

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  always_comb begin
    entry.pos         = pos;
    entry.vel         = vel;
    entry.rest_length = rest_length;
    entry.mass        = mass;
    entry.last        = last;
    if (!cmd) begin
      entry.op = dynamic ? OP_BEGIN_DYN : OP_BEGIN_STATIC;
    end else begin
      // links on a static particle do nothing
      entry.op = dyn_flag ? OP_LINK : OP_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dyn_flag <= 1'b0;
    end else if (push && !cmd) begin
      dyn_flag <= dynamic;
    end
  end

endmodule

// ----- sv/sdfa_queue.sv -----
// ----------------------------------------------------------------------------
// sdfa_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module sdfa_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sdfa_pkg::entry_t   wr_entry,
  input  logic               pop,
  output sdfa_pkg::entry_t   rd_entry,
  output logic               empty,
  output logic               full
);
  import sdfa_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  entry_t        slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign empty    = (count == '0);
  assign full     = (count == (PW+1)'(QDEPTH));
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (PW+1)'(QDEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

endmodule

// ----- sv/sdfa_isqrt.sv -----
// ----------------------------------------------------------------------------
// sdfa_isqrt
// Integer square root of a 64-bit value, two bits of the radicand per cycle.
// ----------------------------------------------------------------------------
module sdfa_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ----- sv/sdfa_div.sv -----
// ----------------------------------------------------------------------------
// sdfa_div
// Restoring divider for one direction component: (m << FRAC_BITS) / len.
// ----------------------------------------------------------------------------
module sdfa_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [32:0]            m,
  input  logic [32:0]            len,
  output logic [FRAC_BITS+1:0]   quot,
  output logic                   done
);

  localparam int QW = FRAC_BITS + 2;
  localparam int CW = $clog2(QW);

  logic [32:0]   rem;
  logic [QW-1:0] feed;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [33:0]   trial;
  logic          ge;

  // m <= len + 1, so the quotient fits FRAC_BITS+2 bits and m >> 2 < len
  assign trial = {rem, feed[QW-1]};
  assign ge    = trial >= {1'b0, len};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {2'b00, m[32:2]};
      feed <= {m[1:0], {FRAC_BITS{1'b0}}};
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? 33'(trial - {1'b0, len}) : trial[32:0];
      feed <= feed << 1;
      quot <= {quot[QW-2:0], ge};
    end
  end

endmodule

// ----- sv/sdfa_back.sv -----
// ----------------------------------------------------------------------------
// sdfa_back
// Sequencer that carries out queued items and holds the result register.
// ----------------------------------------------------------------------------
module sdfa_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sdfa_pkg::cfg_t         cfg,
  input  sdfa_pkg::entry_t       head,
  input  logic                   q_empty,
  output logic                   pop,
  output logic                   force_valid,
  input  logic                   force_stall,
  output logic signed [31:0]     force_x,
  output logic signed [31:0]     force_y,
  output logic signed [31:0]     force_z,
  output logic                   saturated
);
  import sdfa_pkg::*;

  localparam int W  = 72;
  localparam int QW = FRAC_BITS + 2;
  localparam logic signed [W-1:0] MAX32  = W'(64'sd2147483647);
  localparam logic signed [W-1:0] MIN32  = -W'(64'sd2147483648);
  localparam logic signed [W-1:0] DOTLIM = W'(64'sd8589934591);
  localparam logic [FRAC_BITS:0]  ONE    = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic signed [W-1:0] shr_tz(input logic signed [W-1:0] x);
    logic [W-1:0] mg;
    logic [W-1:0] r;
    mg = x[W-1] ? W'(-x) : W'(x);
    r  = mg >> FRAC_BITS;
    return x[W-1] ? $signed(-r) : $signed(r);
  endfunction

  function automatic logic over(input logic signed [W-1:0] x,
                                input logic signed [W-1:0] lo,
                                input logic signed [W-1:0] hi);
    return (x > hi) || (x < lo);
  endfunction

  function automatic logic signed [W-1:0] clamp(input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] lo,
                                                input logic signed [W-1:0] hi);
    logic signed [W-1:0] r;
    r = x;
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end
    return r;
  endfunction

  bstate_t state, state_next;

  entry_t                  cur;
  logic signed [31:0]      own_pos  [3];
  logic signed [31:0]      own_vel  [3];
  logic signed [31:0]      force_acc[3];
  logic                    is_dyn;
  logic                    clip_seen;
  logic signed [32:0]      d        [3];
  logic signed [32:0]      dv       [3];
  logic [32:0]             m        [3];
  logic                    sh;
  logic [63:0]             sq       [3];
  logic [32:0]             len;
  logic signed [QW-1:0]    u        [3];
  logic signed [W-1:0]     prod     [3];
  logic signed [34:0]      dot;
  logic signed [W-1:0]     elastic;
  logic signed [W-1:0]     damp;
  logic signed [31:0]      scal;

  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [31:0]             root;
  logic                    div_start;
  logic [2:0]              div_done;
  logic [QW-1:0]           quot     [3];
  logic                    load_out;

  logic signed [W-1:0]     dot_sum;
  logic signed [W-1:0]     dot_s;
  logic signed [W-1:0]     scal_sum;
  logic signed [W-1:0]     upd      [3];
  logic signed [W-1:0]     grav_s   [3];
  logic signed [33:0]      stretch;

  logic [32:0]             mag_c    [3];
  logic                    sh_c;
  logic [31:0]             half_c   [3];
  logic [63:0]             sq_c     [3];

  assign sqrt_start = (state == B_SQ);
  assign div_start  = (state == B_DSTART);

  sdfa_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq[0] + sq[1] + sq[2]),
    .root     (root),
    .done     (sqrt_done)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    sdfa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .m     (m[i]),
      .len   (len),
      .quot  (quot[i]),
      .done  (div_done[i])
    );
  end

  always_comb begin
    dot_sum  = prod[0] + prod[1] + prod[2];
    dot_s    = shr_tz(dot_sum);
    scal_sum = elastic + damp;
    stretch  = $signed({1'b0, len}) - $signed({3'b000, cur.rest_length});
    for (int i = 0; i < 3; i++) begin
      upd[i]    = W'(force_acc[i]) - shr_tz(prod[i]);
      grav_s[i] = shr_tz(prod[i]);
    end
  end

  // magnitudes and squares: computed from the registered differences
  always_comb begin
    sh_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      if (mag_c[i][32] || mag_c[i][31]) begin
        sh_c = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      half_c[i] = sh_c ? mag_c[i][32:1] : mag_c[i][31:0];
      sq_c[i]   = half_c[i] * half_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (head.op)
            OP_BEGIN_DYN: state_next = B_GRAV;
            OP_LINK:      state_next = B_DIFF;
            default:      state_next = B_DONE;
          endcase
        end
      end
      B_GRAV:     state_next = B_GRAV_SUM;
      B_GRAV_SUM: state_next = B_DONE;
      B_DIFF:     state_next = B_MAG;
      B_MAG:      state_next = B_SQ;
      B_SQ:       state_next = B_SQRT;
      B_SQRT: begin
        if (sqrt_done) begin
          // zero separation adds nothing
          state_next = (root == '0) ? B_DONE : B_DSTART;
        end
      end
      B_DSTART: state_next = B_DIV;
      B_DIV: begin
        if (&div_done) begin
          state_next = B_DOT;
        end
      end
      B_DOT:     state_next = B_DOT_SUM;
      B_DOT_SUM: state_next = B_SMUL;
      B_SMUL:    state_next = B_SCAL;
      B_SCAL:    state_next = B_FMUL;
      B_FMUL:    state_next = B_FUPD;
      B_FUPD:    state_next = B_DONE;
      B_DONE: begin
        if (!cur.last) begin
          state_next = B_IDLE;
        end else if (!force_valid || !force_stall) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // particle state
  always_ff @(posedge clk) begin
    if (rst) begin
      is_dyn    <= 1'b0;
      clip_seen <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        own_pos[i]   <= '0;
        own_vel[i]   <= '0;
        force_acc[i] <= '0;
      end
    end else begin
      if (pop && (head.op == OP_BEGIN_DYN || head.op == OP_BEGIN_STATIC)) begin
        is_dyn    <= (head.op == OP_BEGIN_DYN);
        clip_seen <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          own_pos[i]   <= $signed(head.pos[i]);
          own_vel[i]   <= $signed(head.vel[i]);
          force_acc[i] <= '0;
        end
      end
      if (state == B_GRAV_SUM) begin
        for (int i = 0; i < 3; i++) begin
          force_acc[i] <= 32'(clamp(grav_s[i], MIN32, MAX32));
        end
        clip_seen <= over(grav_s[0], MIN32, MAX32) || over(grav_s[1], MIN32, MAX32) ||
                     over(grav_s[2], MIN32, MAX32);
      end
      if (state == B_DOT_SUM && over(dot_s, -DOTLIM, DOTLIM)) begin
        clip_seen <= 1'b1;
      end
      if (state == B_SCAL && over(scal_sum, MIN32, MAX32)) begin
        clip_seen <= 1'b1;
      end
      if (state == B_FUPD) begin
        for (int i = 0; i < 3; i++) begin
          force_acc[i] <= 32'(clamp(upd[i], MIN32, MAX32));
        end
        if (over(upd[0], MIN32, MAX32) || over(upd[1], MIN32, MAX32) ||
            over(upd[2], MIN32, MAX32)) begin
          clip_seen <= 1'b1;
        end
      end
    end
  end

  // link datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    unique case (state)
      B_GRAV: begin
        for (int i = 0; i < 3; i++) begin
          prod[i] <= W'($signed(cfg.gravity[i]) * $signed({1'b0, cur.mass}));
        end
      end
      B_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          d[i]  <= 33'(own_pos[i]) - 33'($signed(cur.pos[i]));
          dv[i] <= 33'(own_vel[i]) - 33'($signed(cur.vel[i]));
        end
      end
      B_MAG: begin
        // squares of halved magnitudes when any component reaches 2^31
        sh <= sh_c;
        for (int i = 0; i < 3; i++) begin
          m[i]  <= mag_c[i];
          sq[i] <= sq_c[i];
        end
      end
      B_DOT: begin
        for (int i = 0; i < 3; i++) begin
          prod[i] <= W'(dv[i] * u[i]);
        end
      end
      B_DOT_SUM: dot <= 35'(clamp(dot_s, -DOTLIM, DOTLIM));
      B_SMUL: begin
        elastic <= shr_tz(W'(stretch * $signed({1'b0, cfg.stiffness})));
        damp    <= shr_tz(W'(dot * $signed({1'b0, cfg.damping})));
      end
      B_SCAL: scal <= 32'(clamp(scal_sum, MIN32, MAX32));
      B_FMUL: begin
        for (int i = 0; i < 3; i++) begin
          prod[i] <= W'(scal * u[i]);
        end
      end
      default: ;
    endcase
    if (state == B_SQRT && sqrt_done) begin
      len <= sh ? {root, 1'b0} : {1'b0, root};
    end
    if (state == B_DIV && (&div_done)) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= d[i][32] ?
                -$signed(QW'((quot[i] > QW'(ONE)) ? QW'(ONE) : quot[i])) :
                 $signed(QW'((quot[i] > QW'(ONE)) ? QW'(ONE) : quot[i]));
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      force_valid <= 1'b0;
    end else if (load_out) begin
      force_valid <= 1'b1;
    end else if (!force_stall) begin
      force_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      force_x   <= force_acc[0];
      force_y   <= force_acc[1];
      force_z   <= force_acc[2];
      saturated <= clip_seen;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   !is_dyn |-> (force_acc[0] == '0 && force_acc[1] == '0 &&
                                force_acc[2] == '0 && !clip_seen))
    else $error("static particle carries force");
  assert property (@(posedge clk) disable iff (rst) sqrt_done |-> state == B_SQRT)
    else $error("square root finished outside its wait state");
  assert property (@(posedge clk) disable iff (rst) div_done[0] |-> state == B_DIV)
    else $error("division finished outside its wait state");
  assert property (@(posedge clk) disable iff (rst) load_out |=> state == B_IDLE)
    else $error("result loaded without returning to idle");

endmodule

// ----- sv/spring_damper_force_accumulator.sv -----
// ----------------------------------------------------------------------------
// spring_damper_force_accumulator
// Net spring-damper force on one particle, accumulated over link items.
// ----------------------------------------------------------------------------
// A dynamic begin runs the gravity steps; a static begin or a skipped link goes
// straight to done. A link runs a 32-step square root and FRAC_BITS+2 divider
// steps; a zero-separation link ends after the square root. The front accepts up
// to two items ahead of the back end; the result is registered when the last
// item's work ends, once any earlier result has been taken.
// Reset clears configuration, particle state and the queue; no clearing pass.
module spring_damper_force_accumulator #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               cmd,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic [30:0]        rest_length,
  input  logic [30:0]        mass,
  input  logic               dynamic,
  input  logic               last,
  output logic               force_valid,
  input  logic               force_stall,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic               saturated
);
  import sdfa_pkg::*;

  cfg_t   cfg;
  entry_t wr_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_empty;
  logic   q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STIFFNESS: cfg.stiffness  <= cfg_data[30:0];
        REG_DAMPING:   cfg.damping    <= cfg_data[30:0];
        REG_GRAVITY_X: cfg.gravity[0] <= cfg_data;
        REG_GRAVITY_Y: cfg.gravity[1] <= cfg_data;
        REG_GRAVITY_Z: cfg.gravity[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  sdfa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .cmd         (cmd),
    .pos         ({pos_z, pos_y, pos_x}),
    .vel         ({vel_z, vel_y, vel_x}),
    .rest_length (rest_length),
    .mass        (mass),
    .dynamic     (dynamic),
    .last        (last),
    .q_full      (q_full),
    .push        (push),
    .entry       (wr_entry)
  );

  sdfa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  sdfa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .force_valid (force_valid),
    .force_stall (force_stall),
    .force_x     (force_x),
    .force_y     (force_y),
    .force_z     (force_z),
    .saturated   (saturated)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spring-damper force accumulator: directed and
// random begin/link sequences under several register settings, with an
// in-bench force model and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sdfa_pkg::*;

  localparam int FB = 16;
  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;
  localparam longint DOTLIM = 64'sd8589934591;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic signed [31:0] fx, fy, fz;
    logic               sat;
  } force_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic cmd = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic [30:0] rest_length = '0, mass = '0;
  logic dynamic = 1'b0, last = 1'b0;
  logic force_valid;
  logic force_stall = 1'b0;
  logic signed [31:0] force_x, force_y, force_z;
  logic saturated;

  spring_damper_force_accumulator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  longint unsigned k_spring, k_damp;
  longint grav [3];
  longint own_p [3], own_v [3], acc [3];
  bit dyn_q, clip_q;
  force_t expected_forces [$];
  int errors = 0;
  int cycles = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) begin clip_q = 1; return hi; end
    if (v < lo) begin clip_q = 1; return lo; end
    return v;
  endfunction

  function automatic longint shr_tz(longint v);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = m >> FB;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mul_k(longint a, longint unsigned k);
    longint unsigned m;
    m = a < 0 ? -a : a;
    m = (m * k) >> FB;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  task automatic apply_link(longint np [3], longint nv [3], longint unsigned rest);
    longint d [3], dv [3], u [3];
    longint unsigned m [3], sum, len, a, q;
    longint dot, scal;
    int sh;
    sh = 0;
    sum = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = own_p[i] - np[i];
      dv[i] = own_v[i] - nv[i];
      m[i] = d[i] < 0 ? -d[i] : d[i];
      if (m[i] >= 64'd1 << 31) sh = 1;
    end
    for (int i = 0; i < 3; i++) begin
      a = m[i] >> sh;
      sum += a * a;
    end
    len = isqrt(sum) << sh;
    if (len == 0) return;
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << FB) / len;
      if (q > 64'd1 << FB) q = 64'd1 << FB;
      u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
      dot += dv[i] * u[i];
    end
    dot = clip(shr_tz(dot), -DOTLIM, DOTLIM);
    scal = clip(mul_k(longint'(len) - longint'(rest), k_spring) + mul_k(dot, k_damp),
                S32MIN, S32MAX);
    for (int i = 0; i < 3; i++)
      acc[i] = clip(acc[i] - shr_tz(scal * u[i]), S32MIN, S32MAX);
  endtask

  task automatic predict_force(bit c, longint p [3], longint v [3], longint unsigned rest,
                               longint unsigned ms, bit dy, bit lst);
    force_t f;
    if (!c) begin
      own_p = p;
      own_v = v;
      dyn_q = dy;
      clip_q = 0;
      for (int i = 0; i < 3; i++)
        acc[i] = dy ? clip(shr_tz(grav[i] * longint'(ms)), S32MIN, S32MAX) : 0;
    end else if (dyn_q) apply_link(p, v, rest);
    if (lst) begin
      f.fx = acc[0][31:0];
      f.fy = acc[1][31:0];
      f.fz = acc[2][31:0];
      f.sat = clip_q;
      expected_forces.insert(expected_forces.size(), f);
    end
  endtask

  task automatic send_item(bit c, logic signed [31:0] p [3], logic signed [31:0] v [3],
                           logic [30:0] rest, logic [30:0] ms, bit dy, bit lst);
    longint pl [3], vl [3];
    int idle;
    idle = $urandom_range(0, 7);
    if (idle != 0) begin
      item_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
    vel_x <= v[0]; vel_y <= v[1]; vel_z <= v[2];
    rest_length <= rest;
    mass <= ms;
    dynamic <= dy;
    last <= lst;
    for (int i = 0; i < 3; i++) begin
      pl[i] = longint'(p[i]);
      vl[i] = longint'(v[i]);
    end
    predict_force(c, pl, vl, 64'(rest), 64'(ms), dy, lst);
    do @(posedge clk); while (item_stall);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STIFFNESS: k_spring = 64'(val[30:0]);
      REG_DAMPING:   k_damp = 64'(val[30:0]);
      REG_GRAVITY_X: grav[0] = longint'(signed'(val));
      REG_GRAVITY_Y: grav[1] = longint'(signed'(val));
      REG_GRAVITY_Z: grav[2] = longint'(signed'(val));
      default: ;
    endcase
  endtask

  // hold until the block is drained, plus the longest link time
  task automatic drain;
    item_valid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] ks, logic [31:0] kd, logic [31:0] gx,
                            logic [31:0] gy, logic [31:0] gz);
    drain();
    write_reg(REG_STIFFNESS, ks);
    write_reg(REG_DAMPING, kd);
    write_reg(REG_GRAVITY_X, gx);
    write_reg(REG_GRAVITY_Y, gy);
    write_reg(REG_GRAVITY_Z, gz);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord(int scale);
    case (scale)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $signed($urandom_range(0, 32'h00000fff)) - 32'sh00000800;
    endcase
  endfunction

  task automatic rand_vec(output logic signed [31:0] vv [3], input int scale);
    for (int i = 0; i < 3; i++) vv[i] = rand_coord(scale);
  endtask

  task automatic test_directed;
    logic signed [31:0] p [3], v [3], z [3];
    z = '{0, 0, 0};
    set_config(32'h0001_0000, 32'h0000_8000, 32'h0, 32'hfff6_0000, 32'h0);
    // link before any begin is ignored
    send_item(1'b1, '{32'sh10000, 0, 0}, z, 31'h0, 31'h0, 1'b1, 1'b1);
    send_item(1'b0, z, z, 31'h0, 31'h2_0000, 1'b1, 1'b0);
    send_item(1'b1, '{32'sh3_0000, 0, 0}, '{32'sh1_0000, 0, 0}, 31'h1_0000, 31'h0,
              1'b0, 1'b0);
    // zero separation adds nothing
    send_item(1'b1, z, '{32'sh5_0000, 0, 0}, 31'h1_0000, 31'h0, 1'b0, 1'b1);
    // keep accumulating after an emitted last
    send_item(1'b1, '{0, 32'sh2_0000, 32'sh2_0000}, z, 31'h0, 31'h0, 1'b0, 1'b1);
    // static particle
    send_item(1'b0, z, z, 31'h0, 31'h7fff_ffff, 1'b0, 1'b0);
    send_item(1'b1, '{32'sh1_0000, 0, 0}, z, 31'h0, 31'h0, 1'b0, 1'b1);
    // extreme positions, halved before the square root
    p = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
    v = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000};
    send_item(1'b0, p, v, 31'h7fff_ffff, 31'h7fff_ffff, 1'b1, 1'b1);
    send_item(1'b1, v, p, 31'h7fff_ffff, 31'h0, 1'b0, 1'b1);
    send_item(1'b1, v, p, 31'h0, 31'h7fff_ffff, 1'b0, 1'b1);
    set_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_item(1'b0, p, v, 31'h0, 31'h7fff_ffff, 1'b1, 1'b1);
    send_item(1'b1, v, p, 31'h7fff_ffff, 31'h0, 1'b0, 1'b1);
    send_item(1'b0, z, z, 31'h0, 31'h0, 1'b1, 1'b0);
    send_item(1'b1, '{32'sh1, 32'sh1, 32'sh1}, '{-32'sh1, 0, 32'sh1}, 31'h0, 31'h0,
              1'b0, 1'b1);
    set_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(1'b0, p, v, 31'h0, 31'h7fff_ffff, 1'b1, 1'b0);
    send_item(1'b1, v, p, 31'h5555, 31'h2aaa, 1'b1, 1'b1);
  endtask

  task automatic test_random(int n_items);
    logic signed [31:0] p [3], v [3];
    int scale, links, sent;
    sent = 0;
    while (sent < n_items) begin
      scale = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) + 1);
      rand_vec(p, scale);
      rand_vec(v, scale);
      if ($urandom_range(0, 15) == 0) begin
        // noise: random fields of any kind
        send_item(1'($urandom_range(0, 1)), p, v, 31'($urandom()), 31'($urandom()),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
        continue;
      end
      links = $urandom_range(0, 4);
      send_item(1'b0, p, v, 31'($urandom()), 31'($urandom_range(0, 9) == 0 ? $urandom() :
                $urandom_range(0, 32'h40000)), $urandom_range(0, 7) != 0, links == 0);
      sent++;
      for (int j = 0; j < links; j++) begin
        rand_vec(p, scale);
        rand_vec(v, scale);
        send_item(1'b1, p, v, 31'($urandom_range(0, 9) == 0 ? $urandom() :
                  $urandom_range(0, 32'h80000)), 31'($urandom()), 1'($urandom_range(0, 1)),
                  j == links - 1 || $urandom_range(0, 7) == 0);
        sent++;
      end
    end
  endtask

  task automatic test_settings;
    set_config(32'h0001_0000, 32'h0000_4000, 32'h0, 32'hfff6_3000, 32'h0);
    test_random(500);
    // pause the sender until every force has come back
    drain();
    set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    test_random(350);
    set_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    test_random(200);
    set_config($urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000),
               $urandom(), $urandom(), $urandom());
    test_random(480);
  endtask

  // result side: random stall, compare each force transaction
  always @(posedge clk) begin
    force_t e;
    if (!rst) begin
      if (force_valid && !force_stall) begin
        if (expected_forces.size() == 0) begin
          $display("%0t: unexpected force %h %h %h %b", $realtime, force_x, force_y,
                   force_z, saturated);
          errors++;
        end else begin
          e = expected_forces.pop_front();
          if (force_x !== e.fx || force_y !== e.fy || force_z !== e.fz ||
              saturated !== e.sat) begin
            $display("%0t: force mismatch exp %h %h %h %b act %h %h %h %b", $realtime,
                     e.fx, e.fy, e.fz, e.sat, force_x, force_y, force_z, saturated);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 63) < 24) force_stall <= 1'b0;
      else force_stall <= ($urandom_range(0, 7) < 3);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    k_spring = 0; k_damp = 0;
    for (int i = 0; i < 3; i++) begin
      grav[i] = 0; own_p[i] = 0; own_v[i] = 0; acc[i] = 0;
    end
    dyn_q = 0; clip_q = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/sdfa_pkg.sv
sv/sdfa_front.sv
sv/sdfa_queue.sv
sv/sdfa_isqrt.sv
sv/sdfa_div.sv
sv/sdfa_back.sv
sv/spring_damper_force_accumulator.sv
tb/sv/tb_top.sv
